>>> hw/rtl/sosg_pkg.sv
package sosg_pkg;

    // Default sizes of the oscillator
    localparam int unsigned PHASE_BITS_DEF      = 32;
    localparam int unsigned TABLE_ADDR_BITS_DEF = 10;
    localparam int unsigned SAMPLE_BITS_DEF     = 16;

    // Width of the phase slice held by one accumulator cell
    localparam int unsigned CELL_BITS = 8;

    // Register file
    localparam int unsigned AMP_BITS       = 15;
    localparam int unsigned STEP_BITS      = 32;
    localparam int unsigned APB_DATA_BITS  = 32;
    localparam int unsigned APB_ADDR_BITS  = 3;
    localparam logic [AMP_BITS-1:0]  AMP_RESET  = 15'd2048;
    localparam logic [STEP_BITS-1:0] STEP_RESET = 32'd0;

    // Register index, taken from paddr[2]
    localparam logic REG_AMPLITUDE  = 1'b0;
    localparam logic REG_PHASE_STEP = 1'b1;

    // Input beat: restart flag sits in tdata bit 0
    localparam int unsigned IN_DATA_BITS = 8;

    // pi/2 in Q30
    localparam longint unsigned PI_HALF_Q30 = 64'd1686629713;

    typedef struct packed {
        logic [AMP_BITS-1:0]  amplitude;
        logic [STEP_BITS-1:0] phase_step;
    } cfg_t;

    // Control that travels with an item down the cell row
    typedef struct packed {
        logic restart;
        logic block_end;
        logic carry;
    } cell_ctl_t;

    // Quarter-wave sine entry k: sin(pi/2 * k / 2^tab_bits) with
    // sample_bits-1 fraction bits, rounded half up. Evaluated at elaboration.
    function automatic logic [31:0] quarter_sine(input int unsigned k,
                                                 input int unsigned tab_bits,
                                                 input int unsigned sample_bits);
        longint unsigned x;
        longint unsigned x2;
        longint unsigned term;
        longint unsigned one;
        longint          sum;
        longint          r;
        int unsigned     frac;
        int unsigned     n;
        frac = sample_bits - 1;
        one  = 64'd1 << frac;
        x    = (PI_HALF_Q30 * 64'(k)) >> tab_bits;
        x2   = (x * x) >> 30;
        term = x;
        sum  = longint'(x);
        for (n = 1; n <= 7; n++)
        begin
            term = (term * x2) >> 30;
            case (n)
                1:       term = term / 6;
                2:       term = term / 20;
                3:       term = term / 42;
                4:       term = term / 72;
                5:       term = term / 110;
                6:       term = term / 156;
                default: term = term / 210;
            endcase
            if (n % 2 == 1)
                sum = sum - longint'(term);
            else
                sum = sum + longint'(term);
        end
        if (sum < 0)
            sum = 0;
        r = (sum + (longint'(1) << (30 - frac - 1))) >>> (30 - frac);
        if (r > longint'(one))
            r = longint'(one);
        return r[31:0];
    endfunction

endpackage

>>> hw/rtl/sine_oscillator_sample_generator.sv
// Channel   Dir  Beat contents
// s_axis    in   tdata[0] restart (zero phase first), tlast block end
// m_axis    out  tdata[SAMPLE_BITS-1:0] signed sample, tlast block end copy
// apb       in   reg 0 amplitude (15 b, reset 2048), reg 1 phase_step (32 b)
//
// Takes one beat per cycle, sustained; ready stays high unless the output
// beat is held. The phase adder is cut into registered 8-bit cells, then
// come registered ROM read, multiply and saturate/sign stages. Reset
// zeroes the phase and loads the register defaults. A stalled output
// back-pressures the stages behind it only as far as needed; empty stages
// keep filling.
module sine_oscillator_sample_generator #(
    parameter int unsigned PHASE_BITS      = sosg_pkg::PHASE_BITS_DEF,
    parameter int unsigned TABLE_ADDR_BITS = sosg_pkg::TABLE_ADDR_BITS_DEF,
    parameter int unsigned SAMPLE_BITS     = sosg_pkg::SAMPLE_BITS_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    // slave stream
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [sosg_pkg::IN_DATA_BITS-1:0]   s_tdata,  // [0] restart, rest zero
    input  logic                                s_tlast,
    // master stream
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [((SAMPLE_BITS+7)/8)*8-1:0]    m_tdata,  // [SAMPLE_BITS-1:0] sample
    output logic                                m_tlast,
    // configuration
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [sosg_pkg::APB_ADDR_BITS-1:0]  paddr,
    input  logic [sosg_pkg::APB_DATA_BITS-1:0]  pwdata,
    output logic [sosg_pkg::APB_DATA_BITS-1:0]  prdata,
    output logic                                pready
);

    localparam int unsigned CB            = sosg_pkg::CELL_BITS;
    localparam int unsigned NUM_CELLS     = (PHASE_BITS + CB - 1) / CB;
    localparam int unsigned PHASE_W       = NUM_CELLS * CB;
    localparam int unsigned OUT_DATA_BITS = ((SAMPLE_BITS + 7) / 8) * 8;
    localparam int unsigned SB_W          = sosg_pkg::STEP_BITS;

    sosg_pkg::cfg_t cfg;

    // Handshake and payload between neighbor cells; slot 0 is the input.
    logic                 cell_valid [0:NUM_CELLS];
    logic                 cell_ready [0:NUM_CELLS];
    sosg_pkg::cell_ctl_t  cell_ctl   [0:NUM_CELLS];
    logic [PHASE_W-1:0]   cell_phase [0:NUM_CELLS];
    logic [PHASE_W-1:0]   step_w;

    sosg_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // Step bits above the phase width are dropped; padding bits of the
    // last cell get none, so they never disturb the wrapped phase.
    genvar b;
    generate
        for (b = 0; b < PHASE_W; b++)
        begin : g_step
            if (b < SB_W && b < PHASE_BITS)
            begin : g_bit
                assign step_w[b] = cfg.phase_step[b];
            end
            else
            begin : g_pad
                assign step_w[b] = 1'b0;
            end
        end
    endgenerate

    // Feed the row: no carry into the lowest cell.
    assign cell_valid[0]         = s_tvalid;
    assign s_tready              = cell_ready[0];
    assign cell_ctl[0].restart   = s_tdata[0];
    assign cell_ctl[0].block_end = s_tlast;
    assign cell_ctl[0].carry     = 1'b0;
    assign cell_phase[0]         = '0;

    genvar i;
    generate
        for (i = 0; i < NUM_CELLS; i++)
        begin : g_cell
            sosg_phase_cell #(
                .PHASE_W (PHASE_W),
                .IDX     (i)
            ) u_cell (
                .clk        (clk),
                .rst_n      (rst_n),
                .in_valid   (cell_valid[i]),
                .in_ready   (cell_ready[i]),
                .in_ctl     (cell_ctl[i]),
                .in_phase   (cell_phase[i]),
                .step_slice (step_w[i*CB +: CB]),
                .out_valid  (cell_valid[i+1]),
                .out_ready  (cell_ready[i+1]),
                .out_ctl    (cell_ctl[i+1]),
                .out_phase  (cell_phase[i+1])
            );
        end
    endgenerate

    // Phase is fully assembled at the end of the row; turn it into a sample.
    sosg_shaper #(
        .PHASE_W         (PHASE_W),
        .PHASE_BITS      (PHASE_BITS),
        .TABLE_ADDR_BITS (TABLE_ADDR_BITS),
        .SAMPLE_BITS     (SAMPLE_BITS),
        .OUT_DATA_BITS   (OUT_DATA_BITS)
    ) u_shaper (
        .clk       (clk),
        .rst_n     (rst_n),
        .amplitude (cfg.amplitude),
        .in_valid  (cell_valid[NUM_CELLS]),
        .in_ready  (cell_ready[NUM_CELLS]),
        .in_ctl    (cell_ctl[NUM_CELLS]),
        .in_phase  (cell_phase[NUM_CELLS]),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

endmodule

>>> hw/rtl/sosg_regs.sv
module sosg_regs (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic [sosg_pkg::APB_ADDR_BITS-1:0]   paddr,
    input  logic [sosg_pkg::APB_DATA_BITS-1:0]   pwdata,
    output logic [sosg_pkg::APB_DATA_BITS-1:0]   prdata,
    output logic                                 pready,
    output sosg_pkg::cfg_t                       cfg
);

    logic [sosg_pkg::AMP_BITS-1:0]  amplitude_reg;
    logic [sosg_pkg::STEP_BITS-1:0] phase_step_reg;
    logic                           wr_en;
    logic                           reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_idx = paddr[2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            amplitude_reg  <= sosg_pkg::AMP_RESET;
            phase_step_reg <= sosg_pkg::STEP_RESET;
        end
        else if (wr_en)
        begin
            case (reg_idx)
                sosg_pkg::REG_AMPLITUDE:  amplitude_reg  <= pwdata[sosg_pkg::AMP_BITS-1:0];
                sosg_pkg::REG_PHASE_STEP: phase_step_reg <= pwdata[sosg_pkg::STEP_BITS-1:0];
                default:                  ;
            endcase
        end
    end

    always_comb
    begin
        case (reg_idx)
            sosg_pkg::REG_AMPLITUDE:  prdata = sosg_pkg::APB_DATA_BITS'(amplitude_reg);
            sosg_pkg::REG_PHASE_STEP: prdata = sosg_pkg::APB_DATA_BITS'(phase_step_reg);
            default:                  prdata = '0;
        endcase
    end

    assign cfg.amplitude  = amplitude_reg;
    assign cfg.phase_step = phase_step_reg;

endmodule

>>> hw/rtl/sosg_phase_cell.sv
module sosg_phase_cell #(
    parameter int unsigned PHASE_W = 32,
    parameter int unsigned IDX     = 0
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  sosg_pkg::cell_ctl_t             in_ctl,
    input  logic [PHASE_W-1:0]              in_phase,
    input  logic [sosg_pkg::CELL_BITS-1:0]  step_slice,
    output logic                            out_valid,
    input  logic                            out_ready,
    output sosg_pkg::cell_ctl_t             out_ctl,
    output logic [PHASE_W-1:0]              out_phase
);

    localparam int unsigned W = sosg_pkg::CELL_BITS;

    logic [W-1:0]        slice_reg;
    logic [W-1:0]        slice_next;
    logic [W-1:0]        cur;
    logic [W:0]          sum;
    logic                valid_reg;
    sosg_pkg::cell_ctl_t ctl_reg;
    sosg_pkg::cell_ctl_t ctl_next;
    logic [PHASE_W-1:0]  phase_reg;
    logic [PHASE_W-1:0]  phase_next;
    logic                load;

    assign in_ready = !valid_reg || out_ready;
    assign load     = in_valid && in_ready;

    // This item sees the slice as it stands (zero on restart), then leaves
    // the advanced slice behind and hands its carry to the next cell.
    always_comb
    begin
        cur        = in_ctl.restart ? '0 : slice_reg;
        sum        = {1'b0, cur} + {1'b0, step_slice} + (W+1)'(in_ctl.carry);
        slice_next = sum[W-1:0];
        ctl_next       = in_ctl;
        ctl_next.carry = sum[W];
        phase_next = in_phase;
        phase_next[IDX*W +: W] = cur;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slice_reg <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            if (load)
            begin
                slice_reg <= slice_next;
                valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            ctl_reg   <= ctl_next;
            phase_reg <= phase_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_ctl   = ctl_reg;
    assign out_phase = phase_reg;

endmodule

>>> hw/rtl/sosg_shaper.sv
module sosg_shaper #(
    parameter int unsigned PHASE_W         = 32,
    parameter int unsigned PHASE_BITS      = sosg_pkg::PHASE_BITS_DEF,
    parameter int unsigned TABLE_ADDR_BITS = sosg_pkg::TABLE_ADDR_BITS_DEF,
    parameter int unsigned SAMPLE_BITS     = sosg_pkg::SAMPLE_BITS_DEF,
    parameter int unsigned OUT_DATA_BITS   = 16
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic [sosg_pkg::AMP_BITS-1:0]   amplitude,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  sosg_pkg::cell_ctl_t             in_ctl,
    input  logic [PHASE_W-1:0]              in_phase,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [OUT_DATA_BITS-1:0]        m_tdata,
    output logic                            m_tlast
);

    localparam int unsigned TA      = TABLE_ADDR_BITS;
    localparam int unsigned SB      = SAMPLE_BITS;
    localparam int unsigned AB      = sosg_pkg::AMP_BITS;
    localparam int unsigned PROD_W  = AB + SB;
    localparam int unsigned MAG_W   = AB + 1;
    localparam int unsigned CMP_W   = (MAG_W > SB) ? MAG_W : SB;
    localparam int unsigned TAB_LEN = (1 << TA) + 1;

    localparam logic [TA:0]      QTR_N   = (TA+1)'(1) << TA;
    localparam logic [CMP_W-1:0] MAG_MAX = CMP_W'({1'b0, {(SB-1){1'b1}}});

    // Quarter-wave sine ROM, contents fixed at elaboration
    logic [SB-1:0] qtab [0:TAB_LEN-1];

    genvar g;
    generate
        for (g = 0; g < TAB_LEN; g++)
        begin : g_rom
            assign qtab[g] = SB'(sosg_pkg::quarter_sine(g, TA, SB));
        end
    endgenerate

    logic [1:0]        quad;
    logic [TA-1:0]     k;
    logic [TA:0]       rom_addr;

    logic              v1_reg, v2_reg, v3_reg;
    logic              r1, r2, r3;
    logic [SB-1:0]     ent_reg;
    logic              neg1_reg, neg2_reg;
    logic              last1_reg, last2_reg, last3_reg;
    logic [PROD_W-1:0] prod_reg;
    logic [PROD_W-1:0] prod_next;
    logic [SB-1:0]     sample_reg;
    logic [SB-1:0]     sample_next;
    logic [CMP_W-1:0]  mag_w;
    logic [CMP_W-1:0]  mag_sat;
    logic [SB-1:0]     mag_sb;

    assign r3 = !v3_reg || m_tready;
    assign r2 = !v2_reg || r3;
    assign r1 = !v1_reg || r2;
    assign in_ready = r1;

    // Odd quadrants run the table backward, the upper half negates.
    assign quad     = in_phase[PHASE_BITS-1 -: 2];
    assign k        = in_phase[PHASE_BITS-3 -: TA];
    assign rom_addr = quad[0] ? (QTR_N - {1'b0, k}) : {1'b0, k};

    assign prod_next = PROD_W'(amplitude) * PROD_W'(ent_reg);

    always_comb
    begin
        mag_w       = CMP_W'(prod_reg[PROD_W-1:SB-1]);
        mag_sat     = (mag_w > MAG_MAX) ? MAG_MAX : mag_w;
        mag_sb      = mag_sat[SB-1:0];
        sample_next = neg2_reg ? (SB'(0) - mag_sb) : mag_sb;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            if (r1)
                v1_reg <= in_valid;
            if (r2)
                v2_reg <= v1_reg;
            if (r3)
                v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (r1 && in_valid)
        begin
            ent_reg   <= qtab[rom_addr];
            neg1_reg  <= quad[1];
            last1_reg <= in_ctl.block_end;
        end
        if (r2 && v1_reg)
        begin
            prod_reg  <= prod_next;
            neg2_reg  <= neg1_reg;
            last2_reg <= last1_reg;
        end
        if (r3 && v2_reg)
        begin
            sample_reg <= sample_next;
            last3_reg  <= last2_reg;
        end
    end

    assign m_tvalid = v3_reg;
    assign m_tdata  = OUT_DATA_BITS'(sample_reg);
    assign m_tlast  = last3_reg;

endmodule

>>> hw/rtl/sosg_checker.sv
module sosg_checker #(
    parameter int unsigned OUT_DATA_BITS = 16
) (
    input logic                                clk,
    input logic                                rst_n,
    input logic                                s_tvalid,
    input logic                                s_tready,
    input logic                                m_tvalid,
    input logic                                m_tready,
    input logic [OUT_DATA_BITS-1:0]            m_tdata,
    input logic                                psel,
    input logic [sosg_pkg::APB_ADDR_BITS-1:0]  paddr,
    input logic [sosg_pkg::APB_DATA_BITS-1:0]  prdata
);

    logic [7:0] pending_reg;
    logic [7:0] pending_next;
    logic       in_beat;
    logic       out_beat;

    assign in_beat  = s_tvalid && s_tready;
    assign out_beat = m_tvalid && m_tready;

    always_comb
    begin
        pending_next = pending_reg;
        if (in_beat && !out_beat)
            pending_next = pending_reg + 8'd1;
        else if (out_beat && !in_beat)
            pending_next = pending_reg - 8'd1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pending_reg <= '0;
        else
            pending_reg <= pending_next;
    end

    // Hold a stalled output beat.
    a_hold_data: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("output beat changed while stalled");

    // Never show a sample that no input beat asked for.
    a_no_invent: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> pending_reg != 8'd0)
        else $error("output beat without pending input");

    // An empty or draining output stage lets the whole pipe advance.
    a_ready_free: assert property (@(posedge clk) disable iff (!rst_n)
        !m_tvalid || m_tready |-> s_tready)
        else $error("input stalled with free output");

    // Amplitude reads back with its upper bits clear.
    a_amp_read: assert property (@(posedge clk) disable iff (!rst_n)
        psel && !paddr[2] |-> prdata[sosg_pkg::APB_DATA_BITS-1:sosg_pkg::AMP_BITS] == '0)
        else $error("amplitude read has stray upper bits");

endmodule

bind sine_oscillator_sample_generator sosg_checker #(
    .OUT_DATA_BITS (((SAMPLE_BITS + 7) / 8) * 8)
) u_sosg_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .psel     (psel),
    .paddr    (paddr),
    .prdata   (prdata)
);

>>> dv/tb_sine_oscillator_sample_generator.sv
module tb_sine_oscillator_sample_generator;

    timeunit 1ns;
    timeprecision 1ps;

    import sosg_pkg::*;

    // Sizes used by the testbench's own oscillator model
    localparam int unsigned PH_BITS   = PHASE_BITS_DEF;
    localparam int unsigned TAB_BITS  = TABLE_ADDR_BITS_DEF;
    localparam int unsigned SMP_BITS  = SAMPLE_BITS_DEF;
    localparam int unsigned FRAC      = SMP_BITS - 1;
    localparam int unsigned QTR       = 1 << TAB_BITS;
    localparam longint unsigned MAG_MAX = (64'd1 << FRAC) - 1;

    // Length of the run and the watchdog
    localparam int unsigned RANDOM_ITEMS = 850;
    localparam int unsigned CYCLE_LIMIT  = 400000;
    // Pipeline is 7 deep; give it a margin when looking for stray beats
    localparam int unsigned TAIL_CYCLES  = 24;

    // One expected output beat
    typedef struct packed {
        logic [SMP_BITS-1:0] sample;
        logic                block_end;
    } tone_beat_t;

    logic                       clk = 1'b0;
    logic                       rst_n = 1'b0;

    logic                       s_tvalid = 1'b0;
    logic                       s_tready;
    logic [IN_DATA_BITS-1:0]    s_tdata = '0;   // [0] restart, [7:1] zero
    logic                       s_tlast = 1'b0;  // block end

    logic                       m_tvalid;
    logic                       m_tready = 1'b0;
    logic [SMP_BITS-1:0]        m_tdata;         // [15:0] signed sample
    logic                       m_tlast;         // block end copy

    logic                       psel = 1'b0;
    logic                       penable = 1'b0;
    logic                       pwrite = 1'b0;
    logic [APB_ADDR_BITS-1:0]   paddr = '0;
    logic [APB_DATA_BITS-1:0]   pwdata = '0;
    logic [APB_DATA_BITS-1:0]   prdata;
    logic                       pready;

    // Oscillator model: quarter-wave table, config copy and phase accumulator
    int unsigned                sine_quarter [0:QTR];
    logic [AMP_BITS-1:0]        cfg_amp  = AMP_RESET;
    logic [STEP_BITS-1:0]       cfg_step = STEP_RESET;
    logic [PH_BITS-1:0]         osc_phase = '0;

    tone_beat_t                 pending_samples [$];
    int unsigned                num_errors  = 0;
    int unsigned                cycle_count = 0;

    // Receiver stall pattern state
    int unsigned                sink_hold_left = 0;
    int unsigned                sink_mode = 0;

    sine_oscillator_sample_generator u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Watchdog: a hung handshake ends the run as a failure
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("** sine_oscillator_sample_generator: FAILED **");
            $finish;
        end
    end

    // sin(pi/2 * k/N) with FRAC fraction bits, rounded half up. Taylor series
    // through x^15 evaluated in Q30, each term derived from the previous one.
    function automatic int unsigned sine_entry(input int unsigned k);
        longint unsigned x;
        longint unsigned x_sq;
        longint unsigned term;
        longint          acc;
        int unsigned     n;
        x    = (PI_HALF_Q30 * longint'(k)) >> TAB_BITS;
        x_sq = (x * x) >> 30;
        term = x;
        acc  = longint'(x);
        for (n = 1; n <= 7; n++)
        begin
            term = ((term * x_sq) >> 30) / longint'((2 * n) * (2 * n + 1));
            if (n % 2 == 1)
                acc = acc - longint'(term);
            else
                acc = acc + longint'(term);
        end
        if (acc < 0)
            acc = 0;
        acc = (acc + (longint'(1) << (30 - FRAC - 1))) >>> (30 - FRAC);
        if (acc > (longint'(1) << FRAC))
            acc = longint'(1) << FRAC;
        return acc[31:0];
    endfunction

    // Produce the sample for one request and advance the accumulator.
    // Quadrants 1 and 3 read the table mirrored, 2 and 3 negate.
    function automatic logic [SMP_BITS-1:0] next_sample(input logic restart);
        logic [1:0]          quad;
        int unsigned         idx;
        int unsigned         entry;
        longint unsigned     mag;
        logic [SMP_BITS-1:0] val;
        if (restart)
            osc_phase = '0;
        quad  = osc_phase[PH_BITS-1 -: 2];
        idx   = osc_phase[PH_BITS-3 -: TAB_BITS];
        entry = quad[0] ? sine_quarter[QTR - idx] : sine_quarter[idx];
        mag   = (longint'(cfg_amp) * longint'(entry)) >> FRAC;
        if (mag > MAG_MAX)
            mag = MAG_MAX;
        val = mag[SMP_BITS-1:0];
        if (quad[1])
            val = -val;
        osc_phase = osc_phase + PH_BITS'(cfg_step);
        return val;
    endfunction

    // Receiver: stretches of always-ready, mostly-ready, mostly-stalled and
    // fully stalled, each of random length
    always @(posedge clk)
    begin
        if (sink_hold_left == 0)
        begin
            sink_mode      = $urandom_range(0, 3);
            sink_hold_left = (sink_mode == 3) ? $urandom_range(1, 12) : $urandom_range(1, 48);
        end
        sink_hold_left = sink_hold_left - 1;
        case (sink_mode)
            0:       m_tready <= 1'b1;
            1:       m_tready <= ($urandom_range(0, 3) != 0);
            2:       m_tready <= ($urandom_range(0, 3) == 0);
            default: m_tready <= 1'b0;
        endcase
    end

    // Check every output beat against the oldest expectation
    always @(posedge clk)
    begin
        tone_beat_t exp_beat;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (pending_samples.size() == 0)
            begin
                $error("unexpected output beat: sample %0d last %0b",
                       $signed(m_tdata), m_tlast);
                num_errors++;
            end
            else
            begin
                exp_beat = pending_samples.pop_front();
                if (m_tdata !== exp_beat.sample)
                begin
                    $error("sample: expected %0d, got %0d",
                           $signed(exp_beat.sample), $signed(m_tdata));
                    num_errors++;
                end
                if (m_tlast !== exp_beat.block_end)
                begin
                    $error("block_end_out: expected %0b, got %0b",
                           exp_beat.block_end, m_tlast);
                    num_errors++;
                end
            end
        end
    end

    // Offer one request beat, hold it until taken, then log its sample
    task automatic send_beat(input logic restart, input logic last_flag);
        tone_beat_t exp_beat;
        s_tvalid <= 1'b1;
        s_tdata  <= {{(IN_DATA_BITS-1){1'b0}}, restart};
        s_tlast  <= last_flag;
        do
            @(posedge clk);
        while (!s_tready);
        exp_beat.sample    = next_sample(restart);
        exp_beat.block_end = last_flag;
        pending_samples.push_back(exp_beat);
    endtask

    // Drop valid for a gap of the given length (at least one)
    task automatic pause_sender(input int unsigned gap);
        s_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
    endtask

    // Drop valid and hold off until every expected sample has come out
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (pending_samples.size() != 0)
            @(posedge clk);
    endtask

    // Setup then access phase; leaves the bus in the access phase so that
    // back-to-back writes never assign psel twice in one step
    task automatic apb_write(input logic idx, input logic [APB_DATA_BITS-1:0] word);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= word;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        // Register takes only its own width; upper bits are ignored
        if (idx == REG_AMPLITUDE)
            cfg_amp = word[AMP_BITS-1:0];
        else
            cfg_step = word[STEP_BITS-1:0];
    endtask

    // Write one or both registers, then release the bus
    task automatic program_regs(input bit wr_amp, input logic [31:0] amp_word,
                                input bit wr_step, input logic [31:0] step_word);
        if (wr_amp)
            apb_write(REG_AMPLITUDE, amp_word);
        if (wr_step)
            apb_write(REG_PHASE_STEP, step_word);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // Defaults after reset: step 0 keeps the phase at zero, so samples are
    // silent; then a quarter-turn step walks the four quadrant corners at the
    // default amplitude
    task automatic test_reset_defaults();
        send_beat(1'b0, 1'b0);
        send_beat(1'b1, 1'b1);
        send_beat(1'b0, 1'b0);
        wait_drained();
        program_regs(1'b0, 32'd0, 1'b1, 32'h4000_0000);
        send_beat(1'b1, 1'b0);
        send_beat(1'b0, 1'b1);
        send_beat(1'b0, 1'b0);
        send_beat(1'b0, 1'b1);
        wait_drained();
    endtask

    // Full-scale amplitude with junk above bit 14; a step just past a quarter
    // turn visits every quadrant at shifting table points, the all-ones step
    // wraps the phase backwards, and zero amplitude silences everything
    task automatic test_quadrant_points();
        program_regs(1'b1, 32'hFFFF_FFFF, 1'b1, 32'h4010_0000);
        send_beat(1'b1, 1'b0);
        for (int i = 0; i < 7; i++)
            send_beat(1'b0, (i % 3) == 0);
        wait_drained();
        program_regs(1'b0, 32'd0, 1'b1, 32'hFFFF_FFFF);
        send_beat(1'b1, 1'b0);
        send_beat(1'b0, 1'b0);
        send_beat(1'b0, 1'b1);
        wait_drained();
        program_regs(1'b1, 32'h0000_8000, 1'b1, $urandom());
        send_beat(1'b0, 1'b1);
        send_beat(1'b0, 1'b0);
        wait_drained();
    endtask

    // Random tones: each phase reprograms the oscillator while idle, then
    // streams requests in bursts with occasional restarts and block ends
    task automatic test_random_tones();
        int unsigned  sent;
        int unsigned  run_len;
        int unsigned  burst_left;
        int unsigned  req_left;
        bit           no_gaps;
        bit           wr_amp;
        bit           wr_step;
        logic [31:0]  amp_word;
        logic [31:0]  step_word;
        logic         restart;
        logic         last_flag;
        sent     = 0;
        req_left = $urandom_range(1, 32);
        while (sent < RANDOM_ITEMS)
        begin
            case ($urandom_range(0, 5))
                0:       amp_word = 32'd0;
                1:       amp_word = 32'h7FFF;
                2:       amp_word = 32'd1;
                default: amp_word = $urandom_range(0, 32767);
            endcase
            amp_word = amp_word | ($urandom() & 32'hFFFF_8000);
            case ($urandom_range(0, 7))
                0:       step_word = 32'd0;
                1:       step_word = 32'hFFFF_FFFF;
                2:       step_word = $urandom_range(1, 1 << 20);
                3:       step_word = $urandom_range(1, 4095) << 20;
                4:       step_word = 32'h4000_0000 + $urandom_range(0, 1 << 21) - (1 << 20);
                default: step_word = $urandom();
            endcase
            wr_amp  = ($urandom_range(0, 3) != 0);
            wr_step = !wr_amp || ($urandom_range(0, 3) != 0);
            program_regs(wr_amp, amp_word, wr_step, step_word);

            run_len    = $urandom_range(20, 120);
            if (run_len > RANDOM_ITEMS - sent)
                run_len = RANDOM_ITEMS - sent;
            no_gaps    = ($urandom_range(0, 3) == 0);
            burst_left = $urandom_range(1, 24);
            for (int i = 0; i < run_len; i++)
            begin
                if (burst_left == 0)
                begin
                    if (!no_gaps && $urandom_range(0, 2) != 0)
                        pause_sender($urandom_range(1, 10));
                    burst_left = $urandom_range(1, 24);
                end
                // Block ends close software requests of random length
                req_left  = req_left - 1;
                last_flag = (req_left == 0);
                if (last_flag)
                    req_left = $urandom_range(1, 32);
                restart = ($urandom_range(0, 19) == 0);
                send_beat(restart, last_flag);
                burst_left--;
                sent++;
            end
            wait_drained();
        end
    endtask

    initial
    begin
        for (int k = 0; k <= QTR; k++)
            sine_quarter[k] = sine_entry(k);

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_defaults();
        test_quadrant_points();
        test_random_tones();

        // Let any stray beat surface before judging
        repeat (TAIL_CYCLES) @(posedge clk);
        if (pending_samples.size() != 0)
        begin
            $error("%0d expected samples never came out", pending_samples.size());
            num_errors++;
        end

        if (num_errors == 0)
            $display("** sine_oscillator_sample_generator: PASSED **");
        else
            $display("** sine_oscillator_sample_generator: FAILED **");
        $finish;
    end

endmodule

>>> filelist.f
hw/rtl/sosg_pkg.sv
hw/rtl/sosg_regs.sv
hw/rtl/sosg_phase_cell.sv
hw/rtl/sosg_shaper.sv
hw/rtl/sine_oscillator_sample_generator.sv
hw/rtl/sosg_checker.sv
dv/tb_sine_oscillator_sample_generator.sv
